// ===== hdl/gre_pkg.sv =====
// Package for the gamma ramp entry block: widths, control struct and constant tables.
`default_nettype none
package gre_pkg;

    localparam int RAMP_ENTRIES = 256;
    localparam int LAST_ENTRY   = RAMP_ENTRIES - 1;
    localparam int IDX_W        = 8;
    localparam int GAMMA_W      = 16;
    localparam int VALUE_W      = 16;
    localparam int D_W          = 36;              // log difference, Q32, up to 4 integer bits
    localparam int NUM_W        = D_W + 8;         // dividend width, log difference times 256
    localparam int DIV_BPS      = 2;               // quotient bits per divider stage
    localparam int DIV_STAGES   = NUM_W / DIV_BPS;
    localparam int FRAC_W       = 32;
    localparam int SHIFT_W      = 5;
    localparam int R_W          = 31;              // Q30 value in [0.5, 1]
    localparam int C_W          = 30;
    localparam int POW_STEPS    = 30;
    localparam int MAX_SHIFT    = 17;
    localparam int SUM_W        = 48;

    typedef struct packed {
        logic valid;
        logic invalid;
        logic zero;
    } gre_ctl_t;

    typedef logic [D_W-1:0] d_table_t [2**IDX_W];
    typedef logic [C_W-1:0] c_table_t [POW_STEPS+1];

    function automatic logic [63:0] log2_q32(input logic [63:0] n);
        logic [63:0] k;
        logic [63:0] z;
        logic [63:0] frac;
        k    = 64'd0;
        frac = 64'd0;
        for (int t = 0; t < 30; t++)
        begin
            if ((n >> (k + 64'd1)) != 64'd0)
                k = k + 64'd1;
        end
        z = n << (64'd30 - k);
        for (int j = 31; j >= 0; j--)
        begin
            z = (z * z) >> 30;
            if (z >= (64'd1 << 31))
            begin
                z    = z >> 1;
                frac = frac | (64'd1 << j);
            end
        end
        return (k << 32) | frac;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = v_in;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int t = 0; t < 32; t++)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic d_table_t build_d_table();
        d_table_t    tbl;
        logic [63:0] l_last;
        logic [63:0] l_idx;
        int          i_c;
        l_last = log2_q32(64'(LAST_ENTRY));
        for (int i = 0; i < 2**IDX_W; i++)
        begin
            i_c = (i > LAST_ENTRY) ? LAST_ENTRY : i;
            l_idx = (i_c == 0) ? 64'd0 : log2_q32(64'(i_c));
            if (i_c == 0 || l_idx > l_last)
                tbl[i] = '0;
            else
                tbl[i] = D_W'(l_last - l_idx);
        end
        return tbl;
    endfunction

    // 2^(-2^-j) in Q30
    function automatic c_table_t build_c_table();
        c_table_t    tbl;
        logic [63:0] c;
        c = 64'd1 << 29;
        tbl[0] = '0;
        for (int j = 1; j <= POW_STEPS; j++)
        begin
            c = int_sqrt(c << 30);
            tbl[j] = C_W'(c);
        end
        return tbl;
    endfunction

    localparam d_table_t D_TABLE = build_d_table();
    localparam c_table_t C_TABLE = build_c_table();

endpackage
`default_nettype wire

// ===== hdl/gre_div.sv =====
// Pipelined restoring divider: exponent = (log difference * 256) / gamma.
`default_nettype none
module gre_div (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              en,
    input  gre_pkg::gre_ctl_t                ctl_in,
    input  wire  [gre_pkg::D_W-1:0]          d_in,
    input  wire  [gre_pkg::GAMMA_W-1:0]      g_in,
    output gre_pkg::gre_ctl_t                ctl_out,
    output logic [gre_pkg::NUM_W-1:0]        e_out
);

    localparam int NW = gre_pkg::NUM_W;
    localparam int GW = gre_pkg::GAMMA_W;
    localparam int NS = gre_pkg::DIV_STAGES;

    gre_pkg::gre_ctl_t ctl_reg [NS];
    logic [NW-1:0]     num_reg [NS];
    logic [NW-1:0]     quo_reg [NS];
    logic [GW-1:0]     rem_reg [NS];
    logic [GW-1:0]     g_reg   [NS];

    genvar s;
    generate
        for (s = 0; s < NS; s++)
        begin : g_stage
            gre_pkg::gre_ctl_t ctl_src;
            logic [NW-1:0]     num_src;
            logic [NW-1:0]     quo_src;
            logic [GW-1:0]     rem_src;
            logic [GW-1:0]     g_src;
            logic [NW-1:0]     num_next;
            logic [NW-1:0]     quo_next;
            logic [GW-1:0]     rem_next;

            if (s == 0)
            begin : g_first
                assign ctl_src = ctl_in;
                assign num_src = {d_in, 8'd0};
                assign quo_src = '0;
                assign rem_src = '0;
                assign g_src   = g_in;
            end
            else
            begin : g_rest
                assign ctl_src = ctl_reg[s-1];
                assign num_src = num_reg[s-1];
                assign quo_src = quo_reg[s-1];
                assign rem_src = rem_reg[s-1];
                assign g_src   = g_reg[s-1];
            end

            always_comb
            begin
                logic [GW:0] r17;
                num_next = num_src;
                quo_next = quo_src;
                rem_next = rem_src;
                for (int b = 0; b < gre_pkg::DIV_BPS; b++)
                begin
                    r17      = {rem_next, num_next[NW-1]};
                    num_next = {num_next[NW-2:0], 1'b0};
                    if (r17 >= {1'b0, g_src})
                    begin
                        r17      = r17 - {1'b0, g_src};
                        quo_next = {quo_next[NW-2:0], 1'b1};
                    end
                    else
                        quo_next = {quo_next[NW-2:0], 1'b0};
                    rem_next = r17[GW-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    ctl_reg[s] <= '0;
                else if (en)
                    ctl_reg[s] <= ctl_src;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[s] <= num_next;
                    quo_reg[s] <= quo_next;
                    rem_reg[s] <= rem_next;
                    g_reg[s]   <= g_src;
                end
            end
        end
    endgenerate

    assign ctl_out = ctl_reg[NS-1];
    assign e_out   = quo_reg[NS-1];

endmodule
`default_nettype wire

// ===== hdl/gre_pow.sv =====
// Pipelined 2^(-e): product of fraction factors, then scale, round and shift.
`default_nettype none
module gre_pow (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              en,
    input  gre_pkg::gre_ctl_t                ctl_in,
    input  wire  [gre_pkg::NUM_W-1:0]        e_in,
    output gre_pkg::gre_ctl_t                ctl_out,
    output logic [gre_pkg::VALUE_W-1:0]      value_out
);

    localparam int RW = gre_pkg::R_W;
    localparam int FW = gre_pkg::FRAC_W;
    localparam int QW = gre_pkg::SHIFT_W;
    localparam int NJ = gre_pkg::POW_STEPS;
    localparam int SW = gre_pkg::SUM_W;
    localparam int VW = gre_pkg::VALUE_W;

    gre_pkg::gre_ctl_t ctl_reg [NJ+1];
    logic [RW-1:0]     r_reg   [NJ+1];
    logic [FW-1:0]     f_reg   [NJ+1];
    logic [QW-1:0]     q_reg   [NJ+1];

    gre_pkg::gre_ctl_t sum_ctl_reg;
    logic [SW-1:0]     sum_reg;
    logic [QW-1:0]     sum_q_reg;
    gre_pkg::gre_ctl_t out_ctl_reg;
    logic [VW-1:0]     out_reg;

    // entry: split the exponent, flag shifts that leave nothing
    gre_pkg::gre_ctl_t ctl0_next;
    logic              big_shift;
    assign big_shift = (e_in[gre_pkg::NUM_W-1:FW] >= (gre_pkg::NUM_W-FW)'(gre_pkg::MAX_SHIFT));
    always_comb
    begin
        ctl0_next      = ctl_in;
        ctl0_next.zero = ctl_in.zero | big_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg[0] <= '0;
        else if (en)
            ctl_reg[0] <= ctl0_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0] <= RW'(1) << 30;
            f_reg[0] <= e_in[FW-1:0];
            q_reg[0] <= e_in[FW+QW-1:FW];
        end
    end

    genvar j;
    generate
        for (j = 1; j <= NJ; j++)
        begin : g_step
            logic [RW+gre_pkg::C_W-1:0] prod;
            logic [RW-1:0]              r_next;

            assign prod   = r_reg[j-1] * gre_pkg::C_TABLE[j];
            assign r_next = f_reg[j-1][FW-j] ? prod[RW+29:30] : r_reg[j-1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    ctl_reg[j] <= '0;
                else if (en)
                    ctl_reg[j] <= ctl_reg[j-1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[j] <= r_next;
                    f_reg[j] <= f_reg[j-1];
                    q_reg[j] <= q_reg[j-1];
                end
            end
        end
    endgenerate

    // scale by 65535 and add the rounding half
    logic [SW-1:0] sum_next;
    assign sum_next = (SW'(r_reg[NJ]) << 16) - SW'(r_reg[NJ])
                    + (SW'(1) << (SW'(29) + SW'(q_reg[NJ])));

    // final shift and clamp; zero for invalid gamma or zero-flagged items
    logic [SW-1:0] shifted;
    logic [VW-1:0] out_next;
    assign shifted = sum_reg >> (SW'(30) + SW'(sum_q_reg));
    always_comb
    begin
        if (sum_ctl_reg.invalid || sum_ctl_reg.zero)
            out_next = '0;
        else if (shifted > SW'({VW{1'b1}}))
            out_next = {VW{1'b1}};
        else
            out_next = shifted[VW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_ctl_reg <= '0;
            out_ctl_reg <= '0;
        end
        else if (en)
        begin
            sum_ctl_reg <= ctl_reg[NJ];
            out_ctl_reg <= sum_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg   <= sum_next;
            sum_q_reg <= q_reg[NJ];
            out_reg   <= out_next;
        end
    end

    assign ctl_out   = out_ctl_reg;
    assign value_out = out_reg;

endmodule
`default_nettype wire

// ===== hdl/gamma_ramp_entry.sv =====
// Top level of the gamma ramp entry generator.
// Takes one entry index per cycle when not stalled and returns the value
// round(65535 * (index/255)^(1/gamma)), gamma being the cfg register in unsigned
// Q8.8 (reset 1.0). A gamma of zero gives value 0 with the invalid flag set in
// m_tuser. There is one table lookup stage, 22 divider stages (two quotient bits
// each), one exponent split stage, 30 stages of the power product (one 31x30
// multiply each) and two scale/shift stages. The whole pipeline advances together
// whenever the output register is empty or taken, so throughput is one item per
// cycle unless m_tready stalls it. Write gamma only while no items are in flight.
`default_nettype none
module gamma_ramp_entry (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // [7:0] entry_index
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,    // [15:0] ramp_value
    output logic [0:0]  m_tuser,    // [0] gamma_invalid
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [15:0] cfg_data    // gamma_exponent, Q8.8
);

    logic [gre_pkg::GAMMA_W-1:0] gamma_reg;
    logic                        en;

    gre_pkg::gre_ctl_t           lut_ctl_reg;
    gre_pkg::gre_ctl_t           lut_ctl_next;
    logic [gre_pkg::D_W-1:0]     lut_d_reg;
    logic [gre_pkg::GAMMA_W-1:0] lut_g_reg;

    gre_pkg::gre_ctl_t           div_ctl;
    logic [gre_pkg::NUM_W-1:0]   div_e;
    gre_pkg::gre_ctl_t           pow_ctl;
    logic [gre_pkg::VALUE_W-1:0] pow_value;

    assign cfg_ready = 1'b1;
    assign en        = !pow_ctl.valid || m_tready;
    assign s_tready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gamma_reg <= 16'd256;
        else if (cfg_valid && cfg_ready)
            gamma_reg <= cfg_data;
    end

    always_comb
    begin
        lut_ctl_next.valid   = s_tvalid;
        lut_ctl_next.invalid = (gamma_reg == '0);
        lut_ctl_next.zero    = (s_tdata == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lut_ctl_reg <= '0;
        else if (en)
            lut_ctl_reg <= lut_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lut_d_reg <= gre_pkg::D_TABLE[s_tdata];
            lut_g_reg <= gamma_reg;
        end
    end

    gre_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (lut_ctl_reg),
        .d_in    (lut_d_reg),
        .g_in    (lut_g_reg),
        .ctl_out (div_ctl),
        .e_out   (div_e)
    );

    gre_pow u_pow (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl_in    (div_ctl),
        .e_in      (div_e),
        .ctl_out   (pow_ctl),
        .value_out (pow_value)
    );

    assign m_tvalid   = pow_ctl.valid;
    assign m_tdata    = pow_value;
    assign m_tuser[0] = pow_ctl.invalid;

endmodule
`default_nettype wire
